FILE: hdl/dbd_pkg.sv
// ============================================================================
// Detection box decode package
// Shared widths, the configuration bundle, the candidate record passed from
// the front end to the back end, and the register index codes.
// ============================================================================
`default_nettype none

package dbd_pkg;

  localparam int BOX_W       = 16;   // Q12.4 box channel
  localparam int SCORE_W     = 16;   // Q0.16 score
  localparam int CLASS_W     = 7;    // signed class index, also class count width
  localparam int INDEX_BITS  = 16;   // candidate index width
  localparam int COORD_W     = 14;   // frame pixel coordinate
  localparam int PAD_W       = 12;
  localparam int SCALE_W     = 24;   // unsigned Q8.16
  localparam int MAX_CLASSES = 64;

  // Edge in Q.5: 2*c +/- w - 32*pad, signed.
  localparam int EDGE_W      = 19;
  localparam int PROD_W      = EDGE_W + SCALE_W + 1;
  localparam int ROUND_SHIFT = 21;
  localparam int ROUND_W     = PROD_W - ROUND_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;

  typedef enum logic [2:0] {
    REG_CONF_THRESHOLD = 3'd0,
    REG_PAD_X          = 3'd1,
    REG_PAD_Y          = 3'd2,
    REG_INV_SCALE      = 3'd3,
    REG_FRAME_WIDTH    = 3'd4,
    REG_FRAME_HEIGHT   = 3'd5,
    REG_CLASS_COUNT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SCORE_W-1:0] conf_threshold;
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [SCALE_W-1:0] inv_scale;
    logic [COORD_W-1:0] frame_width;
    logic [COORD_W-1:0] frame_height;
    logic [CLASS_W-1:0] class_count;
  } cfg_t;

  typedef struct packed {
    logic [BOX_W-1:0]          cx;
    logic [BOX_W-1:0]          cy;
    logic [BOX_W-1:0]          w;
    logic [BOX_W-1:0]          h;
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] class_id;
    logic [INDEX_BITS-1:0]     index;
  } cand_t;

endpackage

`default_nettype wire

FILE: hdl/detection_box_decode_top.sv
// ============================================================================
// Detection box decode top level
// Turns a detector head's channel stream into clamped frame-pixel boxes.
// ============================================================================
//
//   Channel  Direction  Handshake            Word
//   -------  ---------  -------------------  ----------------------------------
//   chan     in         chan_valid/stall     chan_value, one channel per word
//   box      out        box_valid/stall      left, top, right, bottom, class_id,
//                                            best_score, cand_index
//   config   in         APB psel/penable     registers at byte address 4*index
//
// The block takes one channel word every cycle while chan_stall is low; a
// candidate is four box words and class_count score words, and yields at
// most one box. From its last score word it passes the candidate queue,
// edge forming, inv_scale multiply, rounding, and clamp with degenerate check.
// chan_stall rises only when the four-entry candidate queue is full, which
// happens only when box_stall has held the back end for several candidates.
// Reset is synchronous and clears the channel count, running best, candidate
// index, queue and pipeline valids, and restores the register defaults.
// ============================================================================
`default_nettype none

module detection_box_decode_top (
  input  wire                                 clk,
  input  wire                                 rst,
  // Channel stream
  input  wire logic [dbd_pkg::BOX_W-1:0]      chan_value,
  input  wire                                 chan_valid,
  output logic                                chan_stall,
  // Box results
  output logic                                box_valid,
  input  wire                                 box_stall,
  output logic [dbd_pkg::COORD_W-1:0]         box_left,
  output logic [dbd_pkg::COORD_W-1:0]         box_top,
  output logic [dbd_pkg::COORD_W-1:0]         box_right,
  output logic [dbd_pkg::COORD_W-1:0]         box_bottom,
  output logic signed [dbd_pkg::CLASS_W-1:0]  class_id,
  output logic [dbd_pkg::SCORE_W-1:0]         best_score,
  output logic [dbd_pkg::INDEX_BITS-1:0]      cand_index,
  // Register port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire logic [dbd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [dbd_pkg::DATA_W-1:0]     pwdata,
  output logic [dbd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import dbd_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     reg_write;

  logic     q_full;
  logic     push;
  cand_t    push_data;
  logic     q_pop;
  logic     q_valid;
  cand_t    q_data;

  // The register file. Software must write it only while the block is idle,
  // which the block does not enforce. Both ends read these fields directly.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= SCORE_W'(16384);
      cfg.pad_x          <= '0;
      cfg.pad_y          <= '0;
      cfg.inv_scale      <= SCALE_W'(65536);
      cfg.frame_width    <= COORD_W'(640);
      cfg.frame_height   <= COORD_W'(640);
      cfg.class_count    <= CLASS_W'(6);
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_CONF_THRESHOLD: cfg.conf_threshold <= pwdata[SCORE_W-1:0];
        REG_PAD_X:          cfg.pad_x          <= pwdata[PAD_W-1:0];
        REG_PAD_Y:          cfg.pad_y          <= pwdata[PAD_W-1:0];
        REG_INV_SCALE:      cfg.inv_scale      <= pwdata[SCALE_W-1:0];
        REG_FRAME_WIDTH:    cfg.frame_width    <= pwdata[COORD_W-1:0];
        REG_FRAME_HEIGHT:   cfg.frame_height   <= pwdata[COORD_W-1:0];
        REG_CLASS_COUNT:    cfg.class_count    <= pwdata[CLASS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is combinational off the address; unmapped addresses read 0.
  always_comb begin
    unique case (reg_idx)
      REG_CONF_THRESHOLD: prdata = DATA_W'(cfg.conf_threshold);
      REG_PAD_X:          prdata = DATA_W'(cfg.pad_x);
      REG_PAD_Y:          prdata = DATA_W'(cfg.pad_y);
      REG_INV_SCALE:      prdata = DATA_W'(cfg.inv_scale);
      REG_FRAME_WIDTH:    prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT:   prdata = DATA_W'(cfg.frame_height);
      REG_CLASS_COUNT:    prdata = DATA_W'(cfg.class_count);
      default:            prdata = '0;
    endcase
  end

  // Front end: word intake, best-class tracking, threshold test.
  dbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chan_value (chan_value),
    .chan_valid (chan_valid),
    .chan_stall (chan_stall),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Candidates that passed the threshold wait here for the arithmetic.
  dbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back end: corner forming, scaling, rounding, clamping, output register.
  dbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom),
    .class_id   (class_id),
    .best_score (best_score),
    .cand_index (cand_index)
  );

endmodule

`default_nettype wire

FILE: hdl/dbd_front.sv
// ============================================================================
// Detection box decode front end
// Takes one channel word per cycle unless q_full, captures the box channels,
// tracks the running best class, queues each candidate passing the threshold.
// ============================================================================
`default_nettype none

module dbd_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire logic [dbd_pkg::BOX_W-1:0] chan_value,
  input  wire                           chan_valid,
  output logic                          chan_stall,
  input  wire dbd_pkg::cfg_t            cfg,
  input  wire                           q_full,
  output logic                          push,
  output dbd_pkg::cand_t                push_data
);
  import dbd_pkg::*;

  logic [CLASS_W-1:0]        chan_count;
  logic [SCORE_W-1:0]        best_score;
  logic signed [CLASS_W-1:0] best_class;
  logic [BOX_W-1:0]          box_regs [4];
  logic [INDEX_BITS-1:0]     cand_count;

  logic                      accept;
  logic                      is_box;
  logic                      last;
  logic [CLASS_W-1:0]        ncls;
  logic [CLASS_W-1:0]        pos;
  logic [SCORE_W-1:0]        best_score_next;
  logic signed [CLASS_W-1:0] best_class_next;

  always_comb begin
    if (cfg.class_count == '0) begin
      ncls = CLASS_W'(1);
    end else if (cfg.class_count > CLASS_W'(MAX_CLASSES)) begin
      ncls = CLASS_W'(MAX_CLASSES);
    end else begin
      ncls = cfg.class_count;
    end
  end

  assign chan_stall = q_full;
  assign accept     = chan_valid && !q_full;
  assign is_box     = chan_count < CLASS_W'(4);
  assign pos        = chan_count - CLASS_W'(4);
  assign last       = !is_box && ((pos + CLASS_W'(1)) >= ncls);

  always_comb begin
    best_score_next = best_score;
    best_class_next = best_class;
    if (chan_value > best_score) begin
      best_score_next = chan_value;
      best_class_next = $signed(pos);
    end
  end

  assign push = accept && last && (best_score_next >= cfg.conf_threshold);

  always_comb begin
    push_data.cx       = box_regs[0];
    push_data.cy       = box_regs[1];
    push_data.w        = box_regs[2];
    push_data.h        = box_regs[3];
    push_data.score    = best_score_next;
    push_data.class_id = best_class_next;
    push_data.index    = cand_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= '0;
      best_score <= '0;
      best_class <= '1;
      cand_count <= '0;
    end else if (accept) begin
      if (is_box) begin
        chan_count <= chan_count + CLASS_W'(1);
      end else if (last) begin
        chan_count <= '0;
        best_score <= '0;
        best_class <= '1;
        cand_count <= cand_count + INDEX_BITS'(1);
      end else begin
        chan_count <= chan_count + CLASS_W'(1);
        best_score <= best_score_next;
        best_class <= best_class_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_box) begin
      box_regs[chan_count[1:0]] <= chan_value;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dbd_queue.sv
// ============================================================================
// Detection box decode candidate queue
// Short first-in first-out buffer of candidate records between the front
// end and the arithmetic back end.
// ============================================================================
`default_nettype none

module dbd_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire dbd_pkg::cand_t push_data,
  output logic                full,
  input  wire                 pop,
  output logic                q_valid,
  output dbd_pkg::cand_t      q_data
);
  import dbd_pkg::*;

  cand_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dbd_back.sv
// ============================================================================
// Detection box decode back end
// Four-stage pipeline: edges, scale multiply, rounding, clamp and
// degenerate check into the output register.
// ============================================================================
`default_nettype none

module dbd_back (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire dbd_pkg::cfg_t                   cfg,
  input  wire                                  q_valid,
  input  wire dbd_pkg::cand_t                  q_data,
  output logic                                 q_pop,
  output logic                                 box_valid,
  input  wire                                  box_stall,
  output logic [dbd_pkg::COORD_W-1:0]          box_left,
  output logic [dbd_pkg::COORD_W-1:0]          box_top,
  output logic [dbd_pkg::COORD_W-1:0]          box_right,
  output logic [dbd_pkg::COORD_W-1:0]          box_bottom,
  output logic signed [dbd_pkg::CLASS_W-1:0]   class_id,
  output logic [dbd_pkg::SCORE_W-1:0]          best_score,
  output logic [dbd_pkg::INDEX_BITS-1:0]       cand_index
);
  import dbd_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

  typedef struct packed {
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] class_id;
    logic [INDEX_BITS-1:0]     index;
  } meta_t;

  function automatic logic signed [EDGE_W-1:0] edge_of(
    input logic [BOX_W-1:0] c,
    input logic [BOX_W-1:0] s,
    input logic [PAD_W-1:0] pad,
    input logic             high
  );
    logic [EDGE_W-1:0] c2;
    logic [EDGE_W-1:0] sz;
    logic [EDGE_W-1:0] p;
    c2 = {2'b00, c, 1'b0};
    sz = {3'b000, s};
    p  = {2'b00, pad, 5'b00000};
    return high ? $signed(c2 + sz - p) : $signed(c2 - sz - p);
  endfunction

  // Negative products give 0 here, before the clamp.
  function automatic logic [ROUND_W-1:0] round_pos(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] sum;
    sum = $unsigned(p) + ROUND_HALF;
    return p[PROD_W-1] ? '0 : sum[PROD_W-1:ROUND_SHIFT];
  endfunction

  function automatic logic [COORD_W-1:0] clamp_to(
    input logic [ROUND_W-1:0] v,
    input logic [COORD_W-1:0] hi
  );
    return (v > ROUND_W'(hi)) ? hi : v[COORD_W-1:0];
  endfunction

  logic                      adv;

  logic                      s1_valid;
  meta_t                     s1_meta;
  logic signed [EDGE_W-1:0]  s1_l, s1_t, s1_r, s1_b;

  logic                      s2_valid;
  meta_t                     s2_meta;
  logic signed [PROD_W-1:0]  s2_l, s2_t, s2_r, s2_b;

  logic                      s3_valid;
  meta_t                     s3_meta;
  logic [ROUND_W-1:0]        s3_l, s3_t, s3_r, s3_b;

  logic signed [SCALE_W:0]   scale_s;
  logic [COORD_W-1:0]        hi_x, hi_y;
  logic [COORD_W-1:0]        cl_l, cl_t, cl_r, cl_b;
  logic                      keep;

  assign adv     = !box_valid || !box_stall;
  assign q_pop   = adv;
  assign scale_s = $signed({1'b0, cfg.inv_scale});

  assign hi_x = (cfg.frame_width  == '0) ? '0 : cfg.frame_width  - COORD_W'(1);
  assign hi_y = (cfg.frame_height == '0) ? '0 : cfg.frame_height - COORD_W'(1);
  assign cl_l = clamp_to(s3_l, hi_x);
  assign cl_t = clamp_to(s3_t, hi_y);
  assign cl_r = clamp_to(s3_r, cfg.frame_width);
  assign cl_b = clamp_to(s3_b, cfg.frame_height);
  assign keep = s3_valid && (cl_r > cl_l) && (cl_b > cl_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      box_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      box_valid <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= '{score: q_data.score, class_id: q_data.class_id, index: q_data.index};
      s1_l    <= edge_of(q_data.cx, q_data.w, cfg.pad_x, 1'b0);
      s1_r    <= edge_of(q_data.cx, q_data.w, cfg.pad_x, 1'b1);
      s1_t    <= edge_of(q_data.cy, q_data.h, cfg.pad_y, 1'b0);
      s1_b    <= edge_of(q_data.cy, q_data.h, cfg.pad_y, 1'b1);

      s2_meta <= s1_meta;
      s2_l    <= s1_l * scale_s;
      s2_t    <= s1_t * scale_s;
      s2_r    <= s1_r * scale_s;
      s2_b    <= s1_b * scale_s;

      s3_meta <= s2_meta;
      s3_l    <= round_pos(s2_l);
      s3_t    <= round_pos(s2_t);
      s3_r    <= round_pos(s2_r);
      s3_b    <= round_pos(s2_b);

      if (keep) begin
        box_left   <= cl_l;
        box_top    <= cl_t;
        box_right  <= cl_r;
        box_bottom <= cl_b;
        class_id   <= s3_meta.class_id;
        best_score <= s3_meta.score;
        cand_index <= s3_meta.index;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dbd_checker.sv
// ============================================================================
// Detection box decode checker
// Port-level assertions on the box channel, bound to the top level.
// ============================================================================
`default_nettype none

module dbd_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                box_valid,
  input wire                                box_stall,
  input wire logic [dbd_pkg::COORD_W-1:0]   box_left,
  input wire logic [dbd_pkg::COORD_W-1:0]   box_top,
  input wire logic [dbd_pkg::COORD_W-1:0]   box_right,
  input wire logic [dbd_pkg::COORD_W-1:0]   box_bottom,
  input wire logic signed [dbd_pkg::CLASS_W-1:0] class_id,
  input wire logic [dbd_pkg::SCORE_W-1:0]   best_score
);
  import dbd_pkg::*;

  // A word held back by the receiver stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> box_valid)
    else $error("box word dropped while stalled");

  // Degenerate boxes never leave the block.
  a_width: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> box_right > box_left)
    else $error("box with zero or negative width");

  a_height: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> box_bottom > box_top)
    else $error("box with zero or negative height");

  // No winning class means no score ever rose above zero.
  a_no_class: assert property (@(posedge clk) disable iff (rst)
    box_valid && class_id == -CLASS_W'(1) |-> best_score == '0)
    else $error("class_id of -1 with a nonzero score");

  a_reset: assert property (@(posedge clk)
    rst |=> !box_valid)
    else $error("box word offered right after reset");

endmodule

bind detection_box_decode_top dbd_checker u_dbd_checker (
  .clk        (clk),
  .rst        (rst),
  .box_valid  (box_valid),
  .box_stall  (box_stall),
  .box_left   (box_left),
  .box_top    (box_top),
  .box_right  (box_right),
  .box_bottom (box_bottom),
  .class_id   (class_id),
  .best_score (best_score)
);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Detection box decode testbench
// Streams channel words through the decoder and checks every box against a
// predictor of the candidate logic. The run covers register extremes, the
// corner cases of the class count and random traffic with random idling on
// both sides of the block.
// ============================================================================

module tb_top;
  import dbd_pkg::*;

  // One expected box, as it should leave the block.
  typedef struct {
    logic [COORD_W-1:0]        left;
    logic [COORD_W-1:0]        top;
    logic [COORD_W-1:0]        right;
    logic [COORD_W-1:0]        bottom;
    logic signed [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0]        score;
    logic [INDEX_BITS-1:0]     idx;
  } box_rec_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic [BOX_W-1:0]            chan_value = '0;
  logic                        chan_valid = 1'b0;
  logic                        chan_stall;
  logic                        box_valid;
  logic                        box_stall = 1'b0;
  logic [COORD_W-1:0]          box_left;
  logic [COORD_W-1:0]          box_top;
  logic [COORD_W-1:0]          box_right;
  logic [COORD_W-1:0]          box_bottom;
  logic signed [CLASS_W-1:0]   class_id;
  logic [SCORE_W-1:0]          best_score;
  logic [INDEX_BITS-1:0]       cand_index;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [DATA_W-1:0]           pwdata = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  detection_box_decode_top dut (
    .clk(clk), .rst(rst),
    .chan_value(chan_value), .chan_valid(chan_valid), .chan_stall(chan_stall),
    .box_valid(box_valid), .box_stall(box_stall),
    .box_left(box_left), .box_top(box_top), .box_right(box_right),
    .box_bottom(box_bottom), .class_id(class_id), .best_score(best_score),
    .cand_index(cand_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Predictor state: a copy of the registers and of the candidate being built.
  cfg_t                      model_cfg;
  int unsigned               chan_pos = 0;
  logic [SCORE_W-1:0]        lead_score = '0;
  logic signed [CLASS_W-1:0] lead_class = '1;
  logic [BOX_W-1:0]          box_ch [4] = '{default: '0};
  logic [INDEX_BITS-1:0]     cand_seq = '0;

  box_rec_t    pending_boxes[$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned cands_seen = 0;
  int unsigned boxes_checked = 0;
  int unsigned reg_writes = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;

  // Multiplies a Q.5 edge by inv_scale (Q.21 product) and rounds half away
  // from zero back to whole pixels.
  function automatic longint scale_edge(input longint q5);
    longint prod, mag, r;
    prod = q5 * longint'(model_cfg.inv_scale);
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (longint'(1) << 20)) >>> 21;
    return (prod < 0) ? -r : r;
  endfunction

  function automatic longint clip(input longint v, input longint hi);
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return v;
  endfunction

  // Feeds one accepted channel word to the predictor. When the word closes a
  // candidate that passes the threshold and is not degenerate, the expected
  // box is queued.
  function automatic void decode_word(input logic [BOX_W-1:0] v);
    int unsigned ncls;
    longint px, py, l, t, r, b;
    box_rec_t want;
    ncls = model_cfg.class_count;
    if (ncls < 1) ncls = 1;
    if (ncls > MAX_CLASSES) ncls = MAX_CLASSES;
    words_sent++;
    if (chan_pos < 4) begin
      box_ch[chan_pos] = v;
      chan_pos++;
      return;
    end
    // Strictly greater: a tie keeps the earlier class.
    if (v > lead_score) begin
      lead_score = v;
      lead_class = CLASS_W'(chan_pos - 4);
    end
    chan_pos++;
    if (chan_pos - 4 < ncls) return;

    // The index advances for every candidate, kept or not.
    cands_seen++;
    want.idx = cand_seq;
    cand_seq = cand_seq + 1'b1;
    if (lead_score >= model_cfg.conf_threshold) begin
      px = longint'(model_cfg.pad_x) * 32;
      py = longint'(model_cfg.pad_y) * 32;
      l = clip(scale_edge(2 * longint'(box_ch[0]) - longint'(box_ch[2]) - px),
               longint'(model_cfg.frame_width) - 1);
      t = clip(scale_edge(2 * longint'(box_ch[1]) - longint'(box_ch[3]) - py),
               longint'(model_cfg.frame_height) - 1);
      r = clip(scale_edge(2 * longint'(box_ch[0]) + longint'(box_ch[2]) - px),
               longint'(model_cfg.frame_width));
      b = clip(scale_edge(2 * longint'(box_ch[1]) + longint'(box_ch[3]) - py),
               longint'(model_cfg.frame_height));
      if (r > l && b > t) begin
        want.left   = COORD_W'(l);
        want.top    = COORD_W'(t);
        want.right  = COORD_W'(r);
        want.bottom = COORD_W'(b);
        want.cls    = lead_class;
        want.score  = lead_score;
        pending_boxes = {pending_boxes, want};
      end
    end
    chan_pos = 0;
    lead_score = '0;
    lead_class = '1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Every accepted box is held against the oldest expected one.
  always @(posedge clk) begin : check_box
    box_rec_t want;
    if (!rst && box_valid && !box_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("unexpected box word, cand_index %0d", cand_index);
        fail_count++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("box_left", want.left, box_left);
        check_field("box_top", want.top, box_top);
        check_field("box_right", want.right, box_right);
        check_field("box_bottom", want.bottom, box_bottom);
        check_field("class_id", want.cls, class_id);
        check_field("best_score", want.score, best_score);
        check_field("cand_index", want.idx, cand_index);
        boxes_checked++;
      end
    end
  end

  // Receiver back-pressure: stall bursts separated by runs of random length
  // with no stall at all, while idling is on.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      box_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (box_stall) begin
      box_stall <= 1'b0;
      stall_left <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      box_stall <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end
  end

  // Sends one channel word and returns at the edge that accepted it. The
  // sender sometimes goes quiet for a burst first. Called at a rising edge.
  task automatic send_word(input logic [BOX_W-1:0] v);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      chan_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    chan_value <= v;
    chan_valid <= 1'b1;
    @(posedge clk);
    while (chan_stall) @(posedge clk);
    decode_word(v);
  endtask

  task automatic send_box(input logic [BOX_W-1:0] cx, cy, w, h);
    send_word(cx);
    send_word(cy);
    send_word(w);
    send_word(h);
  endtask

  // Stops the stream and waits until every expected box has come out, plus a
  // margin for a candidate that is still in the pipeline but will be dropped.
  task automatic settle();
    chan_valid <= 1'b0;
    @(posedge clk);
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CONF_THRESHOLD: model_cfg.conf_threshold = val[SCORE_W-1:0];
      REG_PAD_X:          model_cfg.pad_x = val[PAD_W-1:0];
      REG_PAD_Y:          model_cfg.pad_y = val[PAD_W-1:0];
      REG_INV_SCALE:      model_cfg.inv_scale = val[SCALE_W-1:0];
      REG_FRAME_WIDTH:    model_cfg.frame_width = val[COORD_W-1:0];
      REG_FRAME_HEIGHT:   model_cfg.frame_height = val[COORD_W-1:0];
      REG_CLASS_COUNT:    model_cfg.class_count = val[CLASS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure_all(input logic [SCORE_W-1:0] th,
                               input logic [PAD_W-1:0] px, py,
                               input logic [SCALE_W-1:0] inv,
                               input logic [COORD_W-1:0] fw, fh,
                               input logic [CLASS_W-1:0] ncls);
    write_reg(REG_CONF_THRESHOLD, DATA_W'(th));
    write_reg(REG_PAD_X, DATA_W'(px));
    write_reg(REG_PAD_Y, DATA_W'(py));
    write_reg(REG_INV_SCALE, DATA_W'(inv));
    write_reg(REG_FRAME_WIDTH, DATA_W'(fw));
    write_reg(REG_FRAME_HEIGHT, DATA_W'(fh));
    write_reg(REG_CLASS_COUNT, DATA_W'(ncls));
  endtask

  // Box channels are mostly plausible boxes; a quarter are any 16-bit value.
  function automatic logic [BOX_W-1:0] random_box_word(input bit is_size);
    if ($urandom_range(0, 3) == 0) return BOX_W'($urandom);
    return is_size ? BOX_W'($urandom_range(0, 4000)) : BOX_W'($urandom_range(0, 12000));
  endfunction

  // Scores lean on the interesting values: zero, full scale and either side
  // of the threshold.
  function automatic logic [SCORE_W-1:0] random_score();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return model_cfg.conf_threshold;
      3: return model_cfg.conf_threshold - 1'b1;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_candidate();
    int unsigned n;
    n = model_cfg.class_count;
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    send_box(random_box_word(1'b0), random_box_word(1'b0),
             random_box_word(1'b1), random_box_word(1'b1));
    for (int i = 0; i < n; i++) send_word(random_score());
  endtask

  task automatic test_random_stream(input int unsigned words);
    int unsigned target;
    target = words_sent + words;
    while (words_sent < target) send_random_candidate();
  endtask

  // Reset values: six classes, threshold one quarter, unit scale. Two equal
  // top scores check that a tie keeps the earlier class.
  task automatic test_default_config();
    send_box(16'd1600, 16'd1280, 16'd640, 16'd320);
    send_word(16'h0000);
    send_word(16'h3000);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'h4000);
    send_word(16'h0001);
  endtask

  // A class count of zero acts as one; with a zero threshold a candidate with
  // no positive score still yields a box, class -1 and score 0. The odd
  // fractions land edges on exact halves.
  task automatic test_no_positive_score();
    settle();
    write_reg(REG_CLASS_COUNT, DATA_W'(0));
    write_reg(REG_CONF_THRESHOLD, DATA_W'(0));
    send_box(16'd808, 16'd808, 16'd320, 16'd160);
    send_word(16'h0000);
  endtask

  // The class count drops while a candidate is half sent: the next score
  // word closes it. The sender waits for all boxes before the write.
  task automatic test_class_count_change();
    settle();
    write_reg(REG_CLASS_COUNT, DATA_W'(3));
    write_reg(REG_CONF_THRESHOLD, DATA_W'(16'h8000));
    send_box(16'd3200, 16'd2400, 16'd800, 16'd800);
    send_word(16'h9000);
    send_word(16'h9001);
    settle();
    write_reg(REG_CLASS_COUNT, DATA_W'(1));
    send_word(16'h0010);
  endtask

  // A zero inverse scale puts every edge at zero, so the box is dropped.
  task automatic test_zero_scale();
    settle();
    write_reg(REG_INV_SCALE, DATA_W'(0));
    send_box(16'd3200, 16'd2400, 16'd800, 16'd800);
    send_word(16'hFFFF);
  endtask

  // A zero frame size clamps everything to zero: dropped as well.
  task automatic test_zero_frame();
    settle();
    write_reg(REG_INV_SCALE, DATA_W'(24'd65536));
    write_reg(REG_FRAME_WIDTH, DATA_W'(0));
    write_reg(REG_FRAME_HEIGHT, DATA_W'(0));
    send_box(16'd3200, 16'd2400, 16'd800, 16'd800);
    send_word(16'hFFFF);
  endtask

  // Largest padding, scale and frame: an all-ones box has negative low edges
  // and saturating high edges; an all-zero box is degenerate.
  task automatic test_edge_extremes();
    settle();
    configure_all(16'h0001, 12'hFFF, 12'hFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF, 7'd1);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h8000);
    send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'hFFFF);
  endtask

  task automatic test_typical_stream();
    settle();
    configure_all(16'd16384, 12'd0, 12'd0, 24'd65536, 14'd640, 14'd480, 7'd4);
    test_random_stream(150);
  endtask

  // All classes in use, zero threshold, largest padding and scale.
  task automatic test_maximum_settings();
    settle();
    configure_all(16'h0000, 12'hFFF, 12'hFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF, 7'd64);
    test_random_stream(140);
  endtask

  // Smallest scale and frame, top threshold, class count above the maximum.
  task automatic test_minimum_settings();
    settle();
    configure_all(16'hFFFF, 12'd0, 12'd0, 24'd1, 14'd1, 14'd1, 7'd127);
    test_random_stream(60);
  endtask

  // Random but mostly plausible settings. The last call runs without idling.
  task automatic test_random_settings(input bit quiet);
    logic [CLASS_W-1:0] ncls;
    settle();
    case ($urandom_range(0, 9))
      0: ncls = '0;
      1: ncls = CLASS_W'(1);
      default: ncls = CLASS_W'($urandom_range(2, 8));
    endcase
    configure_all(SCORE_W'($urandom_range(0, 40000)), PAD_W'($urandom_range(0, 100)),
                  PAD_W'($urandom_range(0, 100)), SCALE_W'($urandom_range(32768, 131072)),
                  COORD_W'($urandom_range(200, 2000)), COORD_W'($urandom_range(200, 2000)),
                  ncls);
    if (quiet) idle_on <= 1'b0;
    test_random_stream(130);
  endtask

  initial begin
    // Predictor registers start at the block's reset values.
    model_cfg.conf_threshold = 16'd16384;
    model_cfg.pad_x = '0;
    model_cfg.pad_y = '0;
    model_cfg.inv_scale = 24'd65536;
    model_cfg.frame_width = 14'd640;
    model_cfg.frame_height = 14'd640;
    model_cfg.class_count = 7'd6;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_no_positive_score();
    test_class_count_change();
    test_zero_scale();
    test_zero_frame();
    test_edge_extremes();
    test_typical_stream();
    test_maximum_settings();
    test_minimum_settings();
    repeat (4) test_random_settings(1'b0);
    test_random_settings(1'b1);

    settle();
    if (pending_boxes.size() != 0) begin
      $error("%0d expected boxes never arrived", pending_boxes.size());
      fail_count++;
    end
    $display("Sent %0d channel words forming %0d candidates; %0d boxes checked.",
             words_sent, cands_seen, boxes_checked);
    $display("Made %0d register writes across directed and random settings, with idling.",
             reg_writes);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout: the run did not complete.");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hdl/dbd_pkg.sv
hdl/dbd_front.sv
hdl/dbd_queue.sv
hdl/dbd_back.sv
hdl/detection_box_decode_top.sv
hdl/dbd_checker.sv
bench/tb_top.sv
